// ----- hw/rtl/bsa_pkg.sv -----
// bitmap slot allocator package: sizes, result and status types, bit helpers
// no dependencies
package bsa_pkg;

    localparam int SLOTS         = 1024;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = (SLOTS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_W        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W         = (MAP_WORD_BITS > 1) ? $clog2(MAP_WORD_BITS) : 1;
    localparam int CNT_W         = $clog2(SLOTS + 1);
    localparam int IDX_W         = 10;
    localparam int OUT_CNT_W     = 11;
    localparam int OUT_CNT_MAX   = (1 << OUT_CNT_W) - 1;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic                 ok;
        logic [IDX_W-1:0]     granted_slot;
        logic                 all_used;
        logic                 none_used;
        logic [OUT_CNT_W-1:0] used_count;
    } res_t;

    typedef struct packed {
        logic             busy;
        logic             all_full;
        logic [CNT_W-1:0] total;
    } stat_t;

    // valid slot bits of map word w
    function automatic logic [MAP_WORD_BITS-1:0] word_mask(input logic [WORD_W-1:0] w);
        int                   first;
        int                   left;
        logic [MAP_WORD_BITS:0] one;
        logic [MAP_WORD_BITS:0] wide;
        first = int'(w) * MAP_WORD_BITS;
        left  = SLOTS - first;
        one   = (MAP_WORD_BITS + 1)'(1);
        if (left >= MAP_WORD_BITS)
        begin
            return '1;
        end
        wide = (one << left) - one;
        return wide[MAP_WORD_BITS-1:0];
    endfunction

    // index of the lowest set bit, zero when none set
    function automatic logic [BIT_W-1:0] lowest_set(input logic [MAP_WORD_BITS-1:0] x);
        logic [MAP_WORD_BITS-1:0] iso;
        logic [BIT_W-1:0]         pos;
        iso = x & (~x + MAP_WORD_BITS'(1));
        pos = '0;
        for (int i = 0; i < MAP_WORD_BITS; i++)
        begin
            if (iso[i])
            begin
                pos = pos | BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- hw/rtl/bitmap_slot_allocator.sv -----
// bitmap slot allocator top level: stream ports, result register, checks
// depends on bsa_pkg and bsa_ctrl
//
// Keeps one used bit per slot in a 16 x 64 map memory, all free after reset.
// A transfer with s_tuser = 0 allocates the lowest free slot; s_tuser = 1 frees
// the slot in s_tdata. One request is in flight at a time: the accept cycle issues
// the read of the chosen map word (picked from a per-word full summary), the
// execute state then modifies it and writes it back, and the result is registered
// in the output register that drives m_tvalid. A finished result waits in that
// register while the next request is accepted, and the modify cycle holds while
// a previous result still waits there. No clearing pass is needed after reset.
module bitmap_slot_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // slot_index[9:0], zero pad
    input  logic        s_tuser,   // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // ok, granted_slot[9:0], all_used, none_used,
                                   // used_count[10:0]
);

    bsa_pkg::res_t  res;
    bsa_pkg::stat_t stat;
    logic           out_free;
    logic           out_valid_reg, out_valid_next;
    logic [23:0]    out_data_reg, out_data_next;

    assign out_free = !out_valid_reg || m_tready;

    bsa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_func (s_tuser),
        .in_idx  (s_tdata[bsa_pkg::IDX_W-1:0]),
        .out_free(out_free),
        .res     (res),
        .stat    (stat)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (res.valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {res.used_count, res.none_used, res.all_used,
                              res.granted_slot, res.ok};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (stat.busy && !s_tready))
        else $error("request accepted while another is in flight");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(res.valid && m_tvalid && !m_tready))
        else $error("pending result overwritten");

    // full summary agrees with the used count
    a_summary_count: assert property (@(posedge clk) disable iff (!rst_n)
        stat.all_full == (32'(stat.total) == 32'(bsa_pkg::SLOTS)))
        else $error("full summary and used count disagree");

    // count never exceeds the slot total
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(stat.total) <= 32'(bsa_pkg::SLOTS))
        else $error("used count out of range");

endmodule

// ----- hw/rtl/bsa_map_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bsa_map_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 64
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/bsa_ctrl.sv -----
// allocator control: word selection from the full-word summary, read-modify-write
// of the map word, used count; depends on bsa_pkg and bsa_map_ram
module bsa_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       in_func,
    input  logic [bsa_pkg::IDX_W-1:0]  in_idx,
    input  logic                       out_free,
    output bsa_pkg::res_t              res,
    output bsa_pkg::stat_t             stat
);

    localparam int WW = bsa_pkg::WORD_W;
    localparam int BW = bsa_pkg::BIT_W;
    localparam int DW = bsa_pkg::MAP_WORD_BITS;
    localparam int CW = bsa_pkg::CNT_W;

    bsa_pkg::state_t state_reg, state_next;
    logic [bsa_pkg::MAP_WORDS-1:0] full_reg, full_next;
    logic [bsa_pkg::MAP_WORDS-1:0] vld_reg, vld_next;
    logic [CW-1:0] total_reg, total_next;
    logic          func_reg, func_next;
    logic          pre_ok_reg, pre_ok_next;
    logic [WW-1:0] word_reg, word_next;
    logic [BW-1:0] bit_reg, bit_next;

    logic          accept;
    logic [WW-1:0] alloc_word;
    logic          alloc_found;
    logic          in_range;
    logic          wr_en;
    logic [DW-1:0] wr_data;
    logic [DW-1:0] rd_data;
    logic [DW-1:0] cur;
    logic [DW-1:0] mask;
    logic [DW-1:0] free_bits;
    logic [BW-1:0] grant_bit;
    logic [DW-1:0] sel_bit;
    logic          ok;
    int            slot_num;
    int            cnt_sat;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == bsa_pkg::ST_IDLE);

    // lowest word that still has a free slot
    always_comb
    begin
        alloc_word  = '0;
        alloc_found = 1'b0;
        for (int i = bsa_pkg::MAP_WORDS - 1; i >= 0; i--)
        begin
            if (!full_reg[i])
            begin
                alloc_word  = WW'(i);
                alloc_found = 1'b1;
            end
        end
    end

    assign in_range = (32'(in_idx) < 32'(bsa_pkg::SLOTS));

    bsa_map_ram #(
        .ADDR_W(WW),
        .DATA_W(DW)
    ) u_map_ram (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(word_reg),
        .wr_data(wr_data),
        .rd_en  (accept),
        .rd_addr(word_next),
        .rd_data(rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bsa_pkg::ST_IDLE;
            full_reg  <= '0;
            vld_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
            vld_reg   <= vld_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        pre_ok_reg <= pre_ok_next;
        word_reg   <= word_next;
        bit_reg    <= bit_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        full_next   = full_reg;
        vld_next    = vld_reg;
        total_next  = total_reg;
        func_next   = func_reg;
        pre_ok_next = pre_ok_reg;
        word_next   = word_reg;
        bit_next    = bit_reg;
        wr_en       = 1'b0;
        wr_data     = '0;
        ok          = 1'b0;
        res         = '0;

        // a word never written since reset reads as all free
        cur       = vld_reg[word_reg] ? rd_data : '0;
        mask      = bsa_pkg::word_mask(word_reg);
        free_bits = ~cur & mask;
        grant_bit = bsa_pkg::lowest_set(free_bits);
        sel_bit   = '0;
        slot_num  = 0;

        case (state_reg)
            bsa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    func_next = in_func;
                    if (in_func == bsa_pkg::FUNC_ALLOC)
                    begin
                        word_next   = alloc_word;
                        bit_next    = '0;
                        pre_ok_next = alloc_found;
                    end
                    else
                    begin
                        word_next   = WW'(in_idx / bsa_pkg::MAP_WORD_BITS);
                        bit_next    = BW'(in_idx % bsa_pkg::MAP_WORD_BITS);
                        pre_ok_next = in_range;
                    end
                    state_next = bsa_pkg::ST_EXEC;
                end
            end
            bsa_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    if (func_reg == bsa_pkg::FUNC_ALLOC)
                    begin
                        sel_bit  = DW'(1) << grant_bit;
                        ok       = pre_ok_reg && (free_bits != '0);
                        wr_data  = cur | sel_bit;
                        slot_num = int'(word_reg) * bsa_pkg::MAP_WORD_BITS + int'(grant_bit);
                    end
                    else
                    begin
                        sel_bit = DW'(1) << bit_reg;
                        ok      = pre_ok_reg && ((cur & sel_bit) != '0);
                        wr_data = cur & ~sel_bit;
                    end
                    if (ok)
                    begin
                        wr_en              = 1'b1;
                        vld_next[word_reg] = 1'b1;
                        full_next[word_reg] = ((wr_data | ~mask) == '1);
                        if (func_reg == bsa_pkg::FUNC_ALLOC)
                        begin
                            total_next = total_reg + CW'(1);
                        end
                        else
                        begin
                            total_next = total_reg - CW'(1);
                        end
                    end
                    res.valid        = 1'b1;
                    res.ok           = ok;
                    res.granted_slot = ok ? slot_num[bsa_pkg::IDX_W-1:0] : '0;
                    res.all_used     = (32'(total_next) == 32'(bsa_pkg::SLOTS));
                    res.none_used    = (total_next == '0);
                    state_next       = bsa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bsa_pkg::ST_IDLE;
            end
        endcase

        cnt_sat = (int'(total_next) > bsa_pkg::OUT_CNT_MAX) ? bsa_pkg::OUT_CNT_MAX
                                                              : int'(total_next);
        res.used_count = cnt_sat[bsa_pkg::OUT_CNT_W-1:0];
    end

    assign stat.busy     = (state_reg != bsa_pkg::ST_IDLE);
    assign stat.all_full = &full_reg;
    assign stat.total    = total_reg;

endmodule

// ----- tb/sv/tb_bitmap_slot_allocator.sv -----
// testbench for bitmap_slot_allocator: directed and random allocate/free traffic
// checked against an in-bench slot map; depends on bsa_pkg and the allocator rtl
module tb_bitmap_slot_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 1000;

    typedef struct packed {
        logic                          ok;
        logic [bsa_pkg::IDX_W-1:0]     granted_slot;
        logic                          all_used;
        logic                          none_used;
        logic [bsa_pkg::OUT_CNT_W-1:0] used_count;
    } slot_result_t;

    // tracks the slot map and the queue of expected results
    class slot_scoreboard;
        bit           slot_used [bsa_pkg::SLOTS];
        int unsigned  used_total;
        slot_result_t pending_q[$];
        int unsigned  failures;

        function new();
            used_total = 0;
            failures   = 0;
        endfunction

        function void report(string msg);
            if (failures < 10)
            begin
                $display("%0t: %s", $realtime, msg);
            end
            failures++;
        endfunction

        function void note_request(logic func, logic [bsa_pkg::IDX_W-1:0] idx);
            slot_result_t r;
            int           s;
            r = '0;
            if (func == bsa_pkg::FUNC_ALLOC)
            begin
                for (s = 0; s < bsa_pkg::SLOTS; s++)
                begin
                    if (!slot_used[s])
                    begin
                        break;
                    end
                end
                if (s < bsa_pkg::SLOTS)
                begin
                    slot_used[s]   = 1'b1;
                    used_total++;
                    r.ok           = 1'b1;
                    r.granted_slot = bsa_pkg::IDX_W'(s);
                end
            end
            else if (int'(idx) < bsa_pkg::SLOTS && slot_used[idx])
            begin
                slot_used[idx] = 1'b0;
                if (used_total > 0)
                begin
                    used_total--;
                end
                r.ok = 1'b1;
            end
            r.all_used   = (used_total == bsa_pkg::SLOTS);
            r.none_used  = (used_total == 0);
            r.used_count = (used_total > bsa_pkg::OUT_CNT_MAX)
                           ? bsa_pkg::OUT_CNT_W'(bsa_pkg::OUT_CNT_MAX)
                           : bsa_pkg::OUT_CNT_W'(used_total);
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [23:0] d);
            slot_result_t want;
            slot_result_t got;
            got.ok           = d[0];
            got.granted_slot = d[bsa_pkg::IDX_W:1];
            got.all_used     = d[bsa_pkg::IDX_W+1];
            got.none_used    = d[bsa_pkg::IDX_W+2];
            got.used_count   = d[bsa_pkg::IDX_W+3 +: bsa_pkg::OUT_CNT_W];
            if (pending_q.size() == 0)
            begin
                report($sformatf("unexpected result, m_tdata %h", d));
                return;
            end
            want = pending_q.pop_front();
            if (got.ok !== want.ok || got.granted_slot !== want.granted_slot
                || got.all_used !== want.all_used || got.none_used !== want.none_used
                || got.used_count !== want.used_count)
            begin
                report($sformatf({"mismatch (expected/actual): ok %0d/%0d slot %0d/%0d ",
                                  "all_used %0d/%0d none_used %0d/%0d count %0d/%0d"},
                                 want.ok, got.ok, want.granted_slot, got.granted_slot,
                                 want.all_used, got.all_used, want.none_used, got.none_used,
                                 want.used_count, got.used_count));
            end
        endfunction

        // some slot currently in use, or any index when the map is empty
        function logic [bsa_pkg::IDX_W-1:0] pick_used_slot();
            int start;
            int s;
            start = $urandom_range(bsa_pkg::SLOTS - 1);
            if (used_total != 0)
            begin
                for (int i = 0; i < bsa_pkg::SLOTS; i++)
                begin
                    s = (start + i) % bsa_pkg::SLOTS;
                    if (slot_used[s])
                    begin
                        return bsa_pkg::IDX_W'(s);
                    end
                end
            end
            return bsa_pkg::IDX_W'(start);
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    slot_scoreboard sb = new();
    int             burst_left = 0;
    int             idle_cycles = 0;
    int             ready_left = 0;
    int             ready_mode = 0;

    bitmap_slot_allocator uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    // receiver: alternating stretches of always-ready, random and stalled
    always @(negedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(3);
            ready_left = (ready_mode == 3) ? $urandom_range(1, 10) : $urandom_range(5, 60);
        end
        ready_left--;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(99) < 70);
            2:       m_tready <= ($urandom_range(99) < 30);
            default: m_tready <= 1'b0;
        endcase
    end

    // result check and watchdog on transfers
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[bitmap_slot_allocator] ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one request transfer; valid stays high inside a burst
    task automatic send_request(logic func, logic [bsa_pkg::IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = ($urandom_range(5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(16 - bsa_pkg::IDX_W){1'b0}}, idx};
        s_tuser  <= func;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        sb.note_request(func, idx);
        burst_left--;
    endtask

    task automatic random_request(int alloc_pct, int used_pct);
        if ($urandom_range(99) < alloc_pct)
        begin
            send_request(bsa_pkg::FUNC_ALLOC, bsa_pkg::IDX_W'($urandom));
        end
        else if ($urandom_range(99) < used_pct)
        begin
            send_request(bsa_pkg::FUNC_FREE, sb.pick_used_slot());
        end
        else
        begin
            send_request(bsa_pkg::FUNC_FREE, bsa_pkg::IDX_W'($urandom));
        end
    endtask

    initial
    begin
        int n;
        int full_hits;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty map: frees at both ends of the index range, then a double free
        send_request(bsa_pkg::FUNC_FREE, 10'd0);
        send_request(bsa_pkg::FUNC_FREE, 10'h3FF);
        send_request(bsa_pkg::FUNC_ALLOC, 10'h3FF);
        send_request(bsa_pkg::FUNC_ALLOC, 10'd0);
        send_request(bsa_pkg::FUNC_ALLOC, 10'h155);
        send_request(bsa_pkg::FUNC_FREE, 10'd1);
        send_request(bsa_pkg::FUNC_FREE, 10'd1);
        // lowest free slot is reused
        send_request(bsa_pkg::FUNC_ALLOC, 10'h2AA);
        send_request(bsa_pkg::FUNC_FREE, 10'd0);
        send_request(bsa_pkg::FUNC_FREE, 10'd2);
        send_request(bsa_pkg::FUNC_FREE, 10'd1);
        send_request(bsa_pkg::FUNC_ALLOC, 10'd0);
        send_request(bsa_pkg::FUNC_ALLOC, 10'd0);
        send_request(bsa_pkg::FUNC_FREE, 10'h2AA);
        send_request(bsa_pkg::FUNC_FREE, 10'h155);
        send_request(bsa_pkg::FUNC_FREE, 10'h3FF);
        send_request(bsa_pkg::FUNC_FREE, 10'd0);
        send_request(bsa_pkg::FUNC_FREE, 10'd1);

        // fill up to full, then keep hitting the full case for a while
        n = 0;
        full_hits = 0;
        while (full_hits < 30 && n < 1400)
        begin
            if (sb.used_total == bsa_pkg::SLOTS)
            begin
                full_hits++;
            end
            random_request(96, 70);
            n++;
        end
        // drain part of the map with mixed traffic
        repeat (400) random_request(25, 85);

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (sb.failures == 0 && sb.pending_q.size() == 0)
        begin
            $display("[bitmap_slot_allocator] OK");
        end
        else
        begin
            $display("[bitmap_slot_allocator] ERROR");
        end
        $finish;
    end

endmodule
